// ===== rtl/core/lprt_pkg.sv =====
`timescale 1ns / 1ps
package lprt_pkg;

  // operation codes
  localparam logic [1:0] OP_QUERY  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam int ADDR_W = 32;
  localparam int LEN_W  = 6;
  localparam int PORT_W = 8;
  localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

  // classified command handed from front to back
  typedef struct packed {
    logic [1:0]        op;
    logic              len_ok;
    logic [ADDR_W-1:0] key;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] nh;
    logic [PORT_W-1:0] port;
  } cmd_t;

  // result beat
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] next_hop;
    logic [PORT_W-1:0] out_port;
    logic              status;
  } res_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_FETCH,
    ST_DONE
  } state_t;

  // low len bits set
  function automatic logic [ADDR_W-1:0] low_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    m = '0;
    if (len >= MAX_LEN) m = '1;
    else if (len != '0) m = ~({ADDR_W{1'b1}} << len[4:0]);
    return m;
  endfunction

endpackage

// ===== rtl/core/longest_prefix_route_table.sv =====
`timescale 1ns / 1ps
// Longest-prefix routing table.
// Input stream s_axis: one beat per command (query, insert/replace, delete).
// Output stream m_axis: exactly one result beat per command, in order.
// The front stage masks the key and queues up to two commands; the back
// stage scans the table one slot a cycle through a registered memory read.
// Each command holds the back stage to accept it, scan slot by slot,
// close the scan, fetch the winning entry and issue the result.
// Query picks the longest matching prefix; a length-0 route matches all.
// Insert replaces a same prefix/length entry or fills the lowest free slot,
// else reports status 1. Delete frees a matching entry.
// Reset empties the table (valid bits cleared) and the queue.
// When m_axis_tready is low the result is held, the back stage waits and
// the front queue fills, then s_axis_tready drops.
module longest_prefix_route_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [1:0] operation, [33:2] address, [39:34] prefix_len, [71:40] next_hop_in,
  // [79:72] port_in
  input  logic [79:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] hit, [32:1] next_hop, [40:33] out_port, [41] status, [47:42] zero
  output logic [47:0]  m_axis_tdata
);

  logic           q_valid, q_ready;
  lprt_pkg::cmd_t q_cmd;
  lprt_pkg::res_t res;

  lprt_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .op(s_axis_tdata[1:0]), .address(s_axis_tdata[33:2]),
    .prefix_len(s_axis_tdata[39:34]), .next_hop_in(s_axis_tdata[71:40]),
    .port_in(s_axis_tdata[79:72]),
    .q_valid, .q_ready, .q_cmd
  );

  lprt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd,
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
  );

  assign m_axis_tdata = {6'd0, res.status, res.out_port, res.next_hop, res.hit};

`ifndef SYNTHESIS
  // a held result stays unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // a result never sets both hit and status
  a_nohit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[41]))
    else $error("hit and status both set");
  // a miss carries zero payload
  a_miss: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[40:1] == '0)
    else $error("miss with nonzero payload");
`endif

endmodule

// ===== rtl/core/lprt_front.sv =====
`timescale 1ns / 1ps
module lprt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          op,
  input  logic [31:0]         address,
  input  logic [5:0]          prefix_len,
  input  logic [31:0]         next_hop_in,
  input  logic [7:0]          port_in,
  output logic                q_valid,
  input  logic                q_ready,
  output lprt_pkg::cmd_t      q_cmd
);

  // two-entry queue
  lprt_pkg::cmd_t slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  lprt_pkg::cmd_t cmd;
  logic push, pop;

  // classify: mask the key of an insert or delete, flag a legal length
  always_comb begin
    cmd.op     = op;
    cmd.len_ok = (prefix_len <= lprt_pkg::MAX_LEN);
    cmd.key    = (op == lprt_pkg::OP_QUERY) ? address
                 : (address & lprt_pkg::low_mask(prefix_len));
    cmd.len    = prefix_len;
    cmd.nh     = next_hop_in;
    cmd.port   = port_in;
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/core/lprt_back.sv =====
`timescale 1ns / 1ps
module lprt_back #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  lprt_pkg::cmd_t q_cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output lprt_pkg::res_t res
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW:0] LAST = (IW+1)'(TABLE_ENTRIES - 1);

  // table memories; valid bits in flops
  logic [31:0] mem_prefix [TABLE_ENTRIES];
  logic [5:0]  mem_len    [TABLE_ENTRIES];
  logic [31:0] mem_nh     [TABLE_ENTRIES];
  logic [7:0]  mem_port   [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;

  lprt_pkg::state_t state, state_next;
  lprt_pkg::cmd_t   cmd;
  logic [IW:0]      idx;
  logic [31:0]      rd_prefix;
  logic [5:0]       rd_len;
  logic [31:0]      rd_nh;
  logic [7:0]       rd_port;
  logic             rd_ok;
  logic             found, have_free;
  logic [5:0]       best_len;
  logic [IW-1:0]    best, free_slot;
  lprt_pkg::res_t   res_next;
  logic             eq, mt;

  // scan reads one slot per cycle
  always_ff @(posedge clk) begin
    rd_prefix <= mem_prefix[idx[IW-1:0]];
    rd_len    <= mem_len[idx[IW-1:0]];
    rd_nh     <= mem_nh[idx[IW-1:0]];
    rd_port   <= mem_port[idx[IW-1:0]];
    rd_ok     <= valid[idx[IW-1:0]];
  end

  assign mt = rd_ok && ((cmd.key & lprt_pkg::low_mask(rd_len)) == rd_prefix);
  assign eq = rd_ok && (rd_prefix == cmd.key) && (rd_len == cmd.len);
  assign q_ready = (state == lprt_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      lprt_pkg::ST_IDLE:  if (q_valid) state_next = lprt_pkg::ST_SCAN;
      lprt_pkg::ST_SCAN:  if (idx == LAST) state_next = lprt_pkg::ST_READ;
      lprt_pkg::ST_READ:  state_next = lprt_pkg::ST_FETCH;
      lprt_pkg::ST_FETCH: state_next = lprt_pkg::ST_DONE;
      lprt_pkg::ST_DONE:  if (!res_valid) state_next = lprt_pkg::ST_IDLE;
      default:            state_next = lprt_pkg::ST_IDLE;
    endcase
  end

  // pending-slot index of the entry in rd_* (registered from idx, as rd_* is)
  logic [IW-1:0] cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lprt_pkg::ST_IDLE;
      valid     <= '0;
      res_valid <= 1'b0;
      idx       <= '0;
    end else begin
      state <= state_next;
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        lprt_pkg::ST_IDLE: begin
          idx <= '0;
          if (q_valid) begin
            cmd       <= q_cmd;
            found     <= 1'b0;
            have_free <= 1'b0;
            best_len  <= '0;
            best      <= '0;
            free_slot <= '0;
          end
        end
        lprt_pkg::ST_SCAN, lprt_pkg::ST_READ: begin
          if (state == lprt_pkg::ST_SCAN) idx <= idx + 1'b1;
          cur <= idx[IW-1:0];
          // examine previous read
          if (state == lprt_pkg::ST_READ || idx != '0) begin
            if (cmd.op == lprt_pkg::OP_QUERY) begin
              if (mt && (!found || rd_len > best_len)) begin
                found <= 1'b1; best_len <= rd_len; best <= cur;
              end
            end else begin
              if (eq && !found) begin
                found <= 1'b1; best <= cur;
              end
              if (!rd_ok && !have_free) begin
                have_free <= 1'b1; free_slot <= cur;
              end
            end
          end
        end
        lprt_pkg::ST_DONE: begin
          if (!res_valid) begin
            res_valid <= 1'b1;
            res       <= res_next;
            if (cmd.len_ok && cmd.op == lprt_pkg::OP_INSERT && !found && have_free)
              valid[free_slot] <= 1'b1;
            if (cmd.len_ok && cmd.op == lprt_pkg::OP_DELETE && found)
              valid[best] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // writes to payload memories
  always_ff @(posedge clk) begin
    if (state == lprt_pkg::ST_DONE && !res_valid && cmd.len_ok
        && cmd.op == lprt_pkg::OP_INSERT) begin
      if (found) begin
        mem_nh[best]   <= cmd.nh;
        mem_port[best] <= cmd.port;
      end else if (have_free) begin
        mem_prefix[free_slot] <= cmd.key;
        mem_len[free_slot]    <= cmd.len;
        mem_nh[free_slot]     <= cmd.nh;
        mem_port[free_slot]   <= cmd.port;
      end
    end
  end

  // result read of the best query entry via a second registered port
  logic [31:0] hit_nh;
  logic [7:0]  hit_port;
  always_ff @(posedge clk) begin
    hit_nh   <= mem_nh[best];
    hit_port <= mem_port[best];
  end

  always_comb begin
    res_next = '0;
    if (cmd.op == lprt_pkg::OP_QUERY) begin
      res_next.hit      = found;
      res_next.next_hop = found ? hit_nh : '0;
      res_next.out_port = found ? hit_port : '0;
    end else if (cmd.op == lprt_pkg::OP_INSERT && cmd.len_ok) begin
      res_next.status = !found && !have_free;
    end
  end

endmodule
